FILE: rtl/lsac_pkg.sv
package lsac_pkg;

  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDR_BITS    = 64;

  localparam int ADDR_W  = 64;
  localparam int TOTAL_W = 32;
  localparam int SBITS_W = 4;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 6;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_IGNORE = 2'd3
  } cmd_t;

  localparam logic [CIDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [CIDX_W-1:0] REG_WAYS        = 2'd2;

  typedef struct packed {
    cmd_t              command;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic               first_hit;
    logic               first_evicted;
    logic               second_hit;
    logic [TOTAL_W-1:0] total_hits;
    logic [TOTAL_W-1:0] total_misses;
    logic [TOTAL_W-1:0] total_evictions;
  } rsp_t;

  typedef struct packed {
    logic wr;
    logic hit;
    logic evict;
  } upd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS
  } state_t;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v, input logic en);
    logic [TOTAL_W-1:0] r;
    r = v;
    if (en && (v != {TOTAL_W{1'b1}})) begin
      r = v + TOTAL_W'(1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/lru_set_assoc_cache_sim_core.sv
// Set-associative cache tag model with true LRU replacement.
// Request channel: a request (command, 64-bit byte address) is taken at a
// rising edge where start is high and busy is low. Load and store make one
// access, modify makes two to the same line, ignored access changes nothing.
// Config port: cfg_we writes cfg_data into register cfg_index (0 set index
// bits, 1 offset bits, 2 ways in use); write only while no request is open.
// Result channel: done is high for one cycle with rsp holding the hit/evict
// flags and the saturating running totals; the receiver cannot stall it.
// Timing: the set row is read from the set memory at the accept edge; the
// next edge does the tag match, the replacement and rank update, the row
// write-back and registers the result. busy is high until that edge, so a
// new request is only taken once the last one is through, and the
// write-back always lands before the next read.
// Reset clears the totals and the config registers (set bits 0, offset
// bits 0, ways 1), then runs a clearing pass that zeroes one set row (valid
// bits, tags, ranks) per cycle: busy stays high until all sets, 64 by
// default, are cleared, and no request is taken before that.
module lru_set_assoc_cache_sim_core
  import lsac_pkg::*;
#(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  req_t               req,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  output logic               done,
  output rsp_t               rsp
);

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W    = RANK_W;

  logic [2:0] set_index_bits;
  logic [5:0] offset_bits;
  logic [3:0] ways_in_use;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   access;
  logic   clearing;

  logic [SET_W-1:0]     clr_set;
  logic                 clr_last;

  logic [ADDR_BITS-1:0] addr_low;
  logic [SBITS_W-1:0]   sbits;
  logic [SET_W-1:0]     set_mask;
  logic [SET_W-1:0]     rd_set;
  logic [6:0]           tag_shift;
  logic [ADDR_BITS-1:0] rd_tag;

  cmd_t                 cmd_q;
  logic [SET_W-1:0]     set_q;
  logic [ADDR_BITS-1:0] tag_q;

  logic [TOTAL_W-1:0]  hit_total;
  logic [TOTAL_W-1:0]  miss_total;
  logic [TOTAL_W-1:0]  evict_total;

  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] rtags;
  logic [MAX_WAYS-1:0][RANK_W-1:0]    rranks;
  logic [MAX_WAYS-1:0]                rvalid;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tags_next;
  logic [MAX_WAYS-1:0][RANK_W-1:0]    ranks_next;
  logic [MAX_WAYS-1:0]                valid_next;
  upd_t                               upd;
  rsp_t                               res;

  logic                               mem_we;
  logic [SET_W-1:0]                   mem_waddr;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] mem_wtags;
  logic [MAX_WAYS-1:0][RANK_W-1:0]    mem_wranks;
  logic [MAX_WAYS-1:0]                mem_wvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= '0;
      offset_bits    <= '0;
      ways_in_use    <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_BITS:    set_index_bits <= cfg_data[2:0];
        REG_OFFSET_BITS: offset_bits    <= cfg_data[5:0];
        REG_WAYS:        ways_in_use    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign clr_last = (clr_set == SET_W'(NUM_SETS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_last) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_ACCESS;
      ST_ACCESS: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    access   = 1'b0;
    clearing = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        busy     = 1'b1;
        clearing = 1'b1;
      end
      ST_IDLE:   busy = 1'b0;
      ST_ACCESS: begin
        busy   = 1'b1;
        access = 1'b1;
      end
      default:   busy = 1'b0;
    endcase
    accept = start && !busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= access;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_set <= '0;
    end else if (clearing) begin
      clr_set <= clr_set + SET_W'(1);
    end
  end

  always_comb begin
    addr_low  = req.address[ADDR_BITS-1:0];
    sbits     = ({1'b0, set_index_bits} > SBITS_W'(MAX_SET_BITS)) ?
                SBITS_W'(MAX_SET_BITS) : {1'b0, set_index_bits};
    set_mask  = (SET_W'(1) << sbits) - SET_W'(1);
    rd_set    = SET_W'(addr_low >> offset_bits) & set_mask;
    tag_shift = 7'(offset_bits) + 7'(sbits);
    rd_tag    = addr_low >> tag_shift;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= req.command;
      set_q <= rd_set;
      tag_q <= rd_tag;
    end
  end

  always_comb begin
    mem_we     = clearing || (access && upd.wr);
    mem_waddr  = clearing ? clr_set : set_q;
    mem_wtags  = clearing ? '0 : tags_next;
    mem_wranks = clearing ? '0 : ranks_next;
    mem_wvalid = clearing ? '0 : valid_next;
  end

  lsac_set_mem #(
    .SET_W     (SET_W),
    .NUM_SETS  (NUM_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS),
    .RANK_W    (RANK_W)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wtags  (mem_wtags),
    .wranks (mem_wranks),
    .wvalid (mem_wvalid),
    .re     (accept),
    .raddr  (rd_set),
    .rtags  (rtags),
    .rranks (rranks),
    .rvalid (rvalid)
  );

  lsac_lookup #(
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS),
    .RANK_W    (RANK_W),
    .WAY_W     (WAY_W)
  ) u_lookup (
    .cmd         (cmd_q),
    .tag         (tag_q),
    .ways_in_use (ways_in_use),
    .tags        (rtags),
    .ranks       (rranks),
    .valid       (rvalid),
    .hits        (hit_total),
    .misses      (miss_total),
    .evictions   (evict_total),
    .tags_next   (tags_next),
    .ranks_next  (ranks_next),
    .valid_next  (valid_next),
    .upd         (upd),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total   <= '0;
      miss_total  <= '0;
      evict_total <= '0;
    end else if (access) begin
      hit_total   <= res.total_hits;
      miss_total  <= res.total_misses;
      evict_total <= res.total_evictions;
    end
  end

  always_ff @(posedge clk) begin
    if (access) begin
      rsp <= res;
    end
  end

endmodule

FILE: rtl/lsac_set_mem.sv
module lsac_set_mem
  import lsac_pkg::*;
#(
  parameter int SET_W     = 6,
  parameter int NUM_SETS  = 64,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 64,
  parameter int RANK_W    = 3
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [SET_W-1:0]                     waddr,
  input  logic [MAX_WAYS-1:0][ADDR_BITS-1:0]   wtags,
  input  logic [MAX_WAYS-1:0][RANK_W-1:0]      wranks,
  input  logic [MAX_WAYS-1:0]                  wvalid,
  input  logic                                 re,
  input  logic [SET_W-1:0]                     raddr,
  output logic [MAX_WAYS-1:0][ADDR_BITS-1:0]   rtags,
  output logic [MAX_WAYS-1:0][RANK_W-1:0]      rranks,
  output logic [MAX_WAYS-1:0]                  rvalid
);

  localparam int ROW_W = MAX_WAYS * (ADDR_BITS + RANK_W + 1);

  logic [ROW_W-1:0] mem [NUM_SETS];
  logic [ROW_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wvalid, wranks, wtags};
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign {rvalid, rranks, rtags} = rdata;

endmodule

FILE: rtl/lsac_lookup.sv
module lsac_lookup
  import lsac_pkg::*;
#(
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 64,
  parameter int RANK_W    = 3,
  parameter int WAY_W     = 3
) (
  input  cmd_t                                 cmd,
  input  logic [ADDR_BITS-1:0]                 tag,
  input  logic [3:0]                           ways_in_use,
  input  logic [MAX_WAYS-1:0][ADDR_BITS-1:0]   tags,
  input  logic [MAX_WAYS-1:0][RANK_W-1:0]      ranks,
  input  logic [MAX_WAYS-1:0]                  valid,
  input  logic [TOTAL_W-1:0]                   hits,
  input  logic [TOTAL_W-1:0]                   misses,
  input  logic [TOTAL_W-1:0]                   evictions,
  output logic [MAX_WAYS-1:0][ADDR_BITS-1:0]   tags_next,
  output logic [MAX_WAYS-1:0][RANK_W-1:0]      ranks_next,
  output logic [MAX_WAYS-1:0]                  valid_next,
  output upd_t                                 upd,
  output rsp_t                                 res
);

  localparam logic [RANK_W-1:0] MAX_RANK = RANK_W'(MAX_WAYS - 1);

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] inv_vec;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    inv_way;
  logic [WAY_W-1:0]    lru_way;
  logic [WAY_W-1:0]    sel_way;
  logic [RANK_W-1:0]   best_rank;
  logic [RANK_W-1:0]   old_rank;
  logic                hit;
  logic                has_inv;
  logic                was_valid;
  logic                active;
  logic [TOTAL_W-1:0]  hits1;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]  = (w == 0) || (5'(w) < {1'b0, ways_in_use});
      hit_vec[w] = in_use[w] && valid[w] && (tags[w] == tag);
      inv_vec[w] = in_use[w] && !valid[w];
    end
    hit     = |hit_vec;
    has_inv = |inv_vec;
    hit_way = '0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (inv_vec[w]) begin
        inv_way = WAY_W'(w);
      end
    end
    lru_way   = '0;
    best_rank = ranks[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (ranks[w] > best_rank)) begin
        lru_way   = WAY_W'(w);
        best_rank = ranks[w];
      end
    end
  end

  always_comb begin
    active    = (cmd != CMD_IGNORE);
    was_valid = hit || !has_inv;
    sel_way   = hit ? hit_way : (has_inv ? inv_way : lru_way);
    old_rank  = ranks[sel_way];
    tags_next = tags;
    if (!hit) begin
      tags_next[sel_way] = tag;
    end
    for (int v = 0; v < MAX_WAYS; v++) begin
      ranks_next[v] = ranks[v];
      if (WAY_W'(v) == sel_way) begin
        ranks_next[v] = '0;
      end else if (in_use[v] && valid[v] && (!was_valid || (ranks[v] < old_rank))
                   && (ranks[v] != MAX_RANK)) begin
        ranks_next[v] = ranks[v] + RANK_W'(1);
      end
    end
    valid_next          = valid;
    valid_next[sel_way] = 1'b1;
    upd.wr    = active;
    upd.hit   = active && hit;
    upd.evict = active && !hit && !has_inv;
  end

  always_comb begin
    hits1                = sat_inc(hits, upd.hit);
    res.first_hit        = upd.hit;
    res.first_evicted    = upd.evict;
    res.second_hit       = (cmd == CMD_MODIFY);
    res.total_hits       = sat_inc(hits1, cmd == CMD_MODIFY);
    res.total_misses     = sat_inc(misses, active && !hit);
    res.total_evictions  = sat_inc(evictions, upd.evict);
  end

endmodule
